// File: rtl/core/qct_pkg.sv
// Shared types, constants and the count-down and edge steps of the quad countdown timer.
package qct_pkg;

    localparam int CHANNELS_DEF      = 4;
    localparam int BUTTON_DIVIDE_DEF = 64;
    localparam int COUNT_MAX_DEF     = 99;

    localparam int FIELD_CH    = 4;   // channel slots in the result fields
    localparam int COUNT_W     = 7;
    localparam int TPS_W       = 20;
    localparam int PULSE_W     = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 20;
    localparam int HIST_W      = 3 * FIELD_CH;

    localparam logic [TPS_W-1:0]   TPS_RESET   = 20'd48000;
    localparam logic [PULSE_W-1:0] PULSE_RESET = 16'd48;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PRESET_A         = 3'd0,
        REG_PRESET_B         = 3'd1,
        REG_PRESET_C         = 3'd2,
        REG_PRESET_D         = 3'd3,
        REG_RESTART_MASK     = 3'd4,
        REG_EXT_CLOCK_MASK   = 3'd5,
        REG_TICKS_PER_SECOND = 3'd6,
        REG_END_PULSE_TICKS  = 3'd7
    } t_reg_idx;

    // Shared per-tick timing from the front end
    typedef struct packed {
        logic level;   // internal seconds timebase level after this tick
        logic turn;    // buttons are edge-checked on this tick
    } t_tick;

    // Rising edges for one channel
    typedef struct packed {
        logic reset_j;
        logic run_j;
        logic adv_j;
        logic reset_b;
        logic run_b;
        logic adv_b;
    } t_lane_evt;

    typedef struct packed {
        logic [COUNT_W-1:0] preset;
        logic               restart;
        logic               ext;
        logic [PULSE_W-1:0] pulse_ticks;
    } t_lane_cfg;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               run;
        logic               gate;
    } t_lane_out;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               run;
        logic               ended;
    } t_lane_st;

    // One decrement: end of count on zero or one, then reload or stop
    function automatic t_lane_st count_down(t_lane_st s, logic [COUNT_W-1:0] preset,
                                            logic restart);
        t_lane_st r;
        r = s;
        if (s.count > 7'd1) begin
            r.count = s.count - 7'd1;
        end else begin
            r.ended = 1'b1;
            if (restart) begin
                r.count = preset;
            end else begin
                r.run   = 1'b0;
                r.count = '0;
            end
        end
        return r;
    endfunction

    // Reset, run toggle, advance in that order
    function automatic t_lane_st apply_edges(t_lane_st s, logic rise_reset, logic rise_run,
                                             logic rise_adv, logic [COUNT_W-1:0] preset,
                                             logic restart);
        t_lane_st r;
        r = s;
        if (rise_reset) begin
            r.count = preset;
        end
        if (rise_run && (r.count != '0)) begin
            r.run = ~r.run;
        end
        if (rise_adv && r.run) begin
            r = count_down(r, preset, restart);
        end
        return r;
    endfunction

endpackage

// File: rtl/core/qct_front.sv
// Shared front end: button divider, internal seconds timebase and edge detection.
module qct_front #(
    parameter int BUTTON_DIVIDE = qct_pkg::BUTTON_DIVIDE_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic [qct_pkg::TPS_W-1:0]   i_tps,
    input  logic [qct_pkg::HIST_W-1:0]  i_jacks,
    input  logic [qct_pkg::HIST_W-1:0]  i_buttons,
    output qct_pkg::t_tick              o_tick,
    output logic [qct_pkg::HIST_W-1:0]  o_jrise,
    output logic [qct_pkg::HIST_W-1:0]  o_brise
);

    localparam int DIV_W = (BUTTON_DIVIDE > 1) ? $clog2(BUTTON_DIVIDE) : 1;
    localparam logic [DIV_W-1:0] DIV_LAST = DIV_W'(BUTTON_DIVIDE - 1);

    logic [DIV_W-1:0]                r_div, n_div;
    logic [qct_pkg::TPS_W-1:0]       r_phase, n_phase;
    logic [qct_pkg::TPS_W:0]         phase_inc;
    logic [qct_pkg::HIST_W-1:0]      r_jhist, r_bhist;

    always_comb begin
        o_tick.turn = (r_div == DIV_LAST);
        n_div       = o_tick.turn ? '0 : r_div + DIV_W'(1);

        phase_inc = {1'b0, r_phase} + (qct_pkg::TPS_W + 1)'(1);
        n_phase   = (phase_inc >= {1'b0, i_tps}) ? '0 : phase_inc[qct_pkg::TPS_W-1:0];
        o_tick.level = ({n_phase, 1'b0} < {1'b0, i_tps});

        o_jrise = i_jacks & ~r_jhist;
        o_brise = i_buttons & ~r_bhist;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div   <= '0;
            r_phase <= '0;
            r_jhist <= '0;
            r_bhist <= '0;
        end else if (i_accept) begin
            r_div   <= n_div;
            r_phase <= n_phase;
            r_jhist <= i_jacks;
            if (o_tick.turn) begin
                r_bhist <= i_buttons;
            end
        end
    end

endmodule

// File: rtl/core/qct_lane.sv
// One timer channel: count, run flag, seconds-timebase edge and end pulse.
module qct_lane (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  qct_pkg::t_tick               i_tick,
    input  qct_pkg::t_lane_evt           i_evt,
    input  qct_pkg::t_lane_cfg           i_cfg,
    input  logic                         i_load,
    input  logic [qct_pkg::COUNT_W-1:0]  i_load_value,
    output qct_pkg::t_lane_out           o_result
);

    logic [qct_pkg::COUNT_W-1:0] r_count;
    logic                        r_run;
    logic                        r_lsl, n_lsl;
    logic [qct_pkg::PULSE_W-1:0] r_timer, n_timer, timer;
    qct_pkg::t_lane_st           st;

    always_comb begin
        st    = '{count: r_count, run: r_run, ended: 1'b0};
        n_lsl = r_lsl;
        // internal clock edge first
        if (i_tick.level) begin
            if (!i_cfg.ext && !r_lsl) begin
                if (r_run) begin
                    st = qct_pkg::count_down(st, i_cfg.preset, i_cfg.restart);
                end
                n_lsl = 1'b1;
            end
        end else begin
            n_lsl = 1'b0;
        end
        st = qct_pkg::apply_edges(st, i_evt.reset_j, i_evt.run_j, i_evt.adv_j,
                                  i_cfg.preset, i_cfg.restart);
        if (i_tick.turn) begin
            st = qct_pkg::apply_edges(st, i_evt.reset_b, i_evt.run_b, i_evt.adv_b,
                                      i_cfg.preset, i_cfg.restart);
        end
        // retrigger: keep the longer of remaining and full pulse
        timer = r_timer;
        if (st.ended && (timer < i_cfg.pulse_ticks)) begin
            timer = i_cfg.pulse_ticks;
        end
        o_result.gate  = (timer != '0);
        n_timer        = o_result.gate ? timer - 16'd1 : timer;
        o_result.count = st.count;
        o_result.run   = st.run;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 7'd1;
            r_run   <= 1'b0;
            r_lsl   <= 1'b0;
            r_timer <= '0;
        end else if (i_load) begin
            r_count <= i_load_value;
        end else if (i_accept) begin
            r_count <= o_result.count;
            r_run   <= o_result.run;
            r_lsl   <= n_lsl;
            r_timer <= n_timer;
        end
    end

endmodule

// File: rtl/core/quad_countdown_timer.sv
// Top level of the quad countdown timer: config registers, lanes, output register.
//
// Four countdown channels advanced by one sample tick per request. Each request
// carries jack and button levels; the block edge-detects them (buttons only on
// every BUTTON_DIVIDE-th tick), runs every channel in its own lane in the same
// cycle and merges the lanes' counts, run flags and end gates into one result.
// The lane update is combinational: up to three chained 7-bit decrements per
// channel, with no register between them. The result sits in one output register
// and appears the cycle after its request is taken. A new request is taken in the
// same cycle as the held result, so requests can follow back to back; the request
// side stalls only while a held result is stalled downstream. Configuration writes
// are taken at any time, always ready, but belong to idle periods; writing a preset
// also loads that channel's count, with the value clamped to 1..COUNT_MAX.
// Channels beyond CHANNELS (at most four) read as zero.
module quad_countdown_timer #(
    parameter int CHANNELS      = qct_pkg::CHANNELS_DEF,
    parameter int BUTTON_DIVIDE = qct_pkg::BUTTON_DIVIDE_DEF,
    parameter int COUNT_MAX     = qct_pkg::COUNT_MAX_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // tick requests
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [3:0]                       i_reset_jacks,
    input  logic [3:0]                       i_run_jacks,
    input  logic [3:0]                       i_advance_jacks,
    input  logic [3:0]                       i_reset_buttons,
    input  logic [3:0]                       i_run_buttons,
    input  logic [3:0]                       i_advance_buttons,
    // results
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [qct_pkg::COUNT_W-1:0]      o_count_a,
    output logic [qct_pkg::COUNT_W-1:0]      o_count_b,
    output logic [qct_pkg::COUNT_W-1:0]      o_count_c,
    output logic [qct_pkg::COUNT_W-1:0]      o_count_d,
    output logic [3:0]                       o_running,
    output logic [3:0]                       o_end_gate,
    // register writes
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [qct_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [qct_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int NL = (CHANNELS < qct_pkg::FIELD_CH) ? CHANNELS : qct_pkg::FIELD_CH;
    localparam logic [qct_pkg::COUNT_W:0] CMAX = (qct_pkg::COUNT_W + 1)'(COUNT_MAX);

    logic accept, cfg_we;

    // configuration registers
    logic [qct_pkg::COUNT_W-1:0] r_preset [NL];
    logic [3:0]                  r_restart_mask;
    logic [3:0]                  r_ext_clock_mask;
    logic [qct_pkg::TPS_W-1:0]   r_tps;
    logic [qct_pkg::PULSE_W-1:0] r_pulse_ticks;
    logic [qct_pkg::COUNT_W-1:0] preset_clamped;

    // front end
    qct_pkg::t_tick              tick;
    logic [qct_pkg::HIST_W-1:0]  jrise, brise;

    // merge
    logic [qct_pkg::COUNT_W-1:0] lane_count [qct_pkg::FIELD_CH];
    logic [3:0]                  lane_run, lane_gate;

    // output register
    logic                        r_out_valid;
    logic [qct_pkg::COUNT_W-1:0] r_count [qct_pkg::FIELD_CH];
    logic [3:0]                  r_running, r_end_gate;

    // Hold a request only while a finished result is stalled downstream
    assign o_in_stall  = r_out_valid && i_out_stall;
    assign accept      = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    // Clamp preset writes to 1..COUNT_MAX
    always_comb begin
        preset_clamped = i_cfg_data[qct_pkg::COUNT_W-1:0];
        if (preset_clamped == '0) begin
            preset_clamped = 7'd1;
        end else if ({1'b0, preset_clamped} > CMAX) begin
            preset_clamped = CMAX[qct_pkg::COUNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NL; i++) begin
                r_preset[i] <= 7'd1;
            end
            r_restart_mask   <= '0;
            r_ext_clock_mask <= '0;
            r_tps            <= qct_pkg::TPS_RESET;
            r_pulse_ticks    <= qct_pkg::PULSE_RESET;
        end else if (cfg_we) begin
            for (int i = 0; i < NL; i++) begin
                if (i_cfg_index == 3'(qct_pkg::REG_PRESET_A) + 3'(i)) begin
                    r_preset[i] <= preset_clamped;
                end
            end
            if (i_cfg_index == qct_pkg::REG_RESTART_MASK) begin
                r_restart_mask <= i_cfg_data[3:0];
            end
            if (i_cfg_index == qct_pkg::REG_EXT_CLOCK_MASK) begin
                r_ext_clock_mask <= i_cfg_data[3:0];
            end
            if (i_cfg_index == qct_pkg::REG_TICKS_PER_SECOND) begin
                r_tps <= i_cfg_data[qct_pkg::TPS_W-1:0];
            end
            if (i_cfg_index == qct_pkg::REG_END_PULSE_TICKS) begin
                r_pulse_ticks <= i_cfg_data[qct_pkg::PULSE_W-1:0];
            end
        end
    end

    // Divider, seconds timebase and edge detection shared by all lanes
    qct_front #(
        .BUTTON_DIVIDE (BUTTON_DIVIDE)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_tps     (r_tps),
        .i_jacks   ({i_advance_jacks, i_run_jacks, i_reset_jacks}),
        .i_buttons ({i_advance_buttons, i_run_buttons, i_reset_buttons}),
        .o_tick    (tick),
        .o_jrise   (jrise),
        .o_brise   (brise)
    );

    // One lane per channel; missing channels read as zero
    for (genvar ch = 0; ch < qct_pkg::FIELD_CH; ch++) begin : g_lane
        if (ch < NL) begin : g_on
            qct_pkg::t_lane_evt evt;
            qct_pkg::t_lane_cfg cfg;
            qct_pkg::t_lane_out res;

            assign evt.reset_j = jrise[ch];
            assign evt.run_j   = jrise[ch + qct_pkg::FIELD_CH];
            assign evt.adv_j   = jrise[ch + 2 * qct_pkg::FIELD_CH];
            assign evt.reset_b = brise[ch];
            assign evt.run_b   = brise[ch + qct_pkg::FIELD_CH];
            assign evt.adv_b   = brise[ch + 2 * qct_pkg::FIELD_CH];

            assign cfg.preset      = r_preset[ch];
            assign cfg.restart     = r_restart_mask[ch];
            assign cfg.ext         = r_ext_clock_mask[ch];
            assign cfg.pulse_ticks = r_pulse_ticks;

            qct_lane u_lane (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_accept     (accept),
                .i_tick       (tick),
                .i_evt        (evt),
                .i_cfg        (cfg),
                .i_load       (cfg_we &&
                               (i_cfg_index == 3'(qct_pkg::REG_PRESET_A) + 3'(ch))),
                .i_load_value (preset_clamped),
                .o_result     (res)
            );

            assign lane_count[ch] = res.count;
            assign lane_run[ch]   = res.run;
            assign lane_gate[ch]  = res.gate;
        end else begin : g_off
            assign lane_count[ch] = '0;
            assign lane_run[ch]   = 1'b0;
            assign lane_gate[ch]  = 1'b0;
        end
    end

    // Output register: load on every accepted tick, drop valid once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            for (int i = 0; i < qct_pkg::FIELD_CH; i++) begin
                r_count[i] <= lane_count[i];
            end
            r_running  <= lane_run;
            r_end_gate <= lane_gate;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_count_a   = r_count[0];
    assign o_count_b   = r_count[1];
    assign o_count_c   = r_count[2];
    assign o_count_d   = r_count[3];
    assign o_running   = r_running;
    assign o_end_gate  = r_end_gate;

endmodule

// File: rtl/core/qct_checker.sv
// Port-level checks of the quad countdown timer and their bind.
module qct_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_stall,
    input logic                         o_out_valid,
    input logic                         i_out_stall,
    input logic [qct_pkg::COUNT_W-1:0]  o_count_a,
    input logic [qct_pkg::COUNT_W-1:0]  o_count_b,
    input logic [3:0]                   o_running
);

    // stall the request side only while a result is held
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("request stalled without a held result");

    // every accepted request yields a result next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_out_valid)
        else $error("accepted request produced no result");

    // a running channel A or B never shows a zero count
    a_run_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_running[0] || o_running[1])) |->
        ((!o_running[0] || (o_count_a != '0)) && (!o_running[1] || (o_count_b != '0))))
        else $error("running channel at count zero");

    // counts of channels A and B stay at or below COUNT_MAX_DEF
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
        ((o_count_a <= 7'(qct_pkg::COUNT_MAX_DEF)) && (o_count_b <= 7'(qct_pkg::COUNT_MAX_DEF))))
        else $error("count above maximum");

    // a stalled result stays valid and channel A's count holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_count_a)))
        else $error("stalled result changed");

endmodule

bind quad_countdown_timer qct_checker u_qct_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_count_a   (o_count_a),
    .o_count_b   (o_count_b),
    .o_running   (o_running)
);
